[hw/rtl/u8cr_pkg.sv]
package u8cr_pkg;

  // Field widths of the result item.
  localparam int unsigned CP_W       = 21;
  localparam int unsigned LINE_NUM_W = 20;
  localparam int unsigned COL_NUM_W  = 16;

  // Default widths of the position counters.
  localparam int unsigned DEFAULT_LINE_BITS   = 20;
  localparam int unsigned DEFAULT_COLUMN_BITS = 16;

  // Input marker codes.
  localparam logic [1:0] MARKER_DATA = 2'd0;
  localparam logic [1:0] MARKER_END  = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_NUL  = 3'd1;
  localparam logic [2:0] ERR_BAD  = 3'd2;
  localparam logic [2:0] ERR_BOM  = 3'd3;
  localparam logic [2:0] ERR_IO   = 3'd4;

  // Character constants.
  localparam logic [7:0]      ASCII_END = 8'h80;
  localparam logic [7:0]      CHAR_LF   = 8'h0A;
  localparam logic [7:0]      CONT_LO   = 8'h80;
  localparam logic [7:0]      CONT_HI   = 8'hBF;
  localparam logic [CP_W-1:0] BOM_CP    = 21'h00FEFF;

  // Classification of a multi-byte sequence.
  localparam logic [1:0] CLS_INVALID = 2'd0;
  localparam logic [1:0] CLS_PARTIAL = 2'd1;
  localparam logic [1:0] CLS_DONE    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] marker;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CP_W-1:0]       code_point;
    logic [LINE_NUM_W-1:0] line_number;
    logic [COL_NUM_W-1:0]  column_number;
    logic [2:0]            error_code;
    logic                  last;
  } out_item_t;

  // Operation of a queued item, as sorted by the front end.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_FAIL
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } q_item_t;

  // Up to four pending bytes, entry 0 is the oldest.
  typedef logic [3:0][7:0] byte_vec_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CP_W-1:0] cp;
    logic [2:0]      width;
  } cls_t;

  // Classify the n bytes at p whose lead byte is at least 0x80.
  function automatic cls_t classify(input byte_vec_t p, input logic [2:0] n);
    cls_t       r;
    logic [2:0] need;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] l;
    logic [7:0] h;
    logic       ok;
    r    = '0;
    need = 3'd0;
    lo   = CONT_LO;
    hi   = CONT_HI;
    ok   = 1'b1;
    if (p[0] inside {[8'hC2:8'hDF]}) begin
      need = 3'd2;
    end else if (p[0] inside {[8'hE0:8'hEF]}) begin
      need = 3'd3;
    end else if (p[0] inside {[8'hF0:8'hF4]}) begin
      need = 3'd4;
    end else begin
      ok = 1'b0;
    end
    // Narrowed second-byte ranges rule out overlong forms, surrogates and
    // values above the last plane.
    case (p[0])
      8'hE0:   lo = 8'hA0;
      8'hED:   hi = 8'h9F;
      8'hF0:   lo = 8'h90;
      8'hF4:   hi = 8'h8F;
      default: ;
    endcase
    for (int i = 1; i < 4; i++) begin
      l = (i == 1) ? lo : CONT_LO;
      h = (i == 1) ? hi : CONT_HI;
      if ((3'(i) < need) && (3'(i) < n) && ((p[i] < l) || (p[i] > h))) begin
        ok = 1'b0;
      end
    end
    if (!ok) begin
      r.status = CLS_INVALID;
    end else if (n < need) begin
      r.status = CLS_PARTIAL;
    end else begin
      r.status = CLS_DONE;
      r.width  = need;
      case (need)
        3'd2:    r.cp = {10'd0, p[0][4:0], p[1][5:0]};
        3'd3:    r.cp = {5'd0, p[0][3:0], p[1][5:0], p[2][5:0]};
        default: r.cp = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
      endcase
    end
    return r;
  endfunction

endpackage

[hw/rtl/u8cr_front.sv]
module u8cr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8cr_pkg::in_item_t  in_item_i,
  output logic                q_valid_o,
  output u8cr_pkg::q_item_t   q_item_o,
  input  logic                q_pop_i
);
  import u8cr_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);

  q_item_t              mem_q [QDepth];
  logic [PtrW-1:0]      wr_ptr_q;
  logic [PtrW-1:0]      wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q;
  logic [PtrW-1:0]      rd_ptr_d;
  logic [PtrW:0]        count_q;
  logic [PtrW:0]        count_d;
  logic                 push;
  logic                 pop;
  q_item_t              new_item;

  // Sort the incoming item into a byte, an end or a failure.
  always_comb begin
    new_item.data = in_item_i.data_byte;
    if (in_item_i.marker == MARKER_DATA) begin
      new_item.op = OP_BYTE;
    end else if (in_item_i.marker == MARKER_END) begin
      new_item.op = OP_END;
    end else begin
      new_item.op = OP_FAIL;
    end
  end

  assign in_ready_o = (count_q != (PtrW + 1)'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (count_q != '0);
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[hw/rtl/u8cr_back.sv]
module u8cr_back #(
  parameter int unsigned LINE_BITS   = u8cr_pkg::DEFAULT_LINE_BITS,
  parameter int unsigned COLUMN_BITS = u8cr_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  u8cr_pkg::q_item_t   q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cr_pkg::out_item_t out_item_o
);
  import u8cr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  localparam logic [LINE_BITS-1:0]   LineMax = {{(LINE_BITS - 1){1'b1}}, 1'b0};
  localparam logic [COLUMN_BITS-1:0] ColMax  = {{(COLUMN_BITS - 1){1'b1}}, 1'b0};

  logic [1:0]             state_q;
  logic [1:0]             state_d;
  byte_vec_t              buf_q;
  byte_vec_t              buf_d;
  logic [2:0]             cnt_q;
  logic [2:0]             cnt_d;
  logic                   flush_q;
  logic                   flush_d;
  logic                   fail_q;
  logic                   fail_d;
  logic [LINE_BITS-1:0]   line_q;
  logic [LINE_BITS-1:0]   line_d;
  logic [COLUMN_BITS-1:0] col_q;
  logic [COLUMN_BITS-1:0] col_d;
  logic [2:0]             lw_q;
  logic [2:0]             lw_d;
  logic                   nl_q;
  logic                   nl_d;
  logic                   out_valid_q;
  logic                   out_valid_d;
  out_item_t              out_q;

  logic [LINE_BITS-1:0]   adv_line;
  logic [COLUMN_BITS-1:0] adv_col;
  logic [COLUMN_BITS:0]   col_sum;
  cls_t                   cls;
  cls_t                   rem_cls;
  byte_vec_t              rem;
  logic [2:0]             rem_cnt;
  logic                   rem_hold;
  logic [2:0]             src;
  logic [2:0]             step_w;
  logic                   step_nl;
  logic                   hold;
  logic                   emit;
  logic                   upd_pos;
  logic                   can_step;
  logic                   want_load;
  out_item_t              res;

  // Pending position advance, applied before every consumed unit.
  always_comb begin
    col_sum = {1'b0, col_q} + (COLUMN_BITS + 1)'(lw_q);
    if (nl_q) begin
      adv_line = (line_q != LineMax) ? line_q + 1'b1 : line_q;
      adv_col  = '0;
    end else begin
      adv_line = line_q;
      adv_col  = (col_sum > {1'b0, ColMax}) ? ColMax : col_sum[COLUMN_BITS-1:0];
    end
  end

  assign can_step = !out_valid_q || out_ready_i;

  // One decoding step on the head of the pending bytes.
  always_comb begin
    cls       = classify(buf_q, cnt_q);
    step_w    = 3'd0;
    step_nl   = 1'b0;
    hold      = 1'b0;
    emit      = 1'b0;
    upd_pos   = 1'b0;
    res.kind          = KIND_CHAR;
    res.code_point    = '0;
    res.line_number   = LINE_NUM_W'({1'b0, adv_line} + 1'b1);
    res.column_number = COL_NUM_W'({1'b0, adv_col} + 1'b1);
    res.error_code    = ERR_NONE;
    res.last          = 1'b0;
    case (state_q)
      ST_DECODE: begin
        upd_pos = 1'b1;
        if (buf_q[0] < ASCII_END) begin
          step_w = 3'd1;
          emit   = 1'b1;
          if (buf_q[0] == 8'h00) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NUL;
          end else begin
            res.code_point = CP_W'(buf_q[0]);
            step_nl        = (buf_q[0] == CHAR_LF);
          end
        end else if ((cls.status == CLS_PARTIAL) && !flush_q) begin
          hold    = 1'b1;
          upd_pos = 1'b0;
        end else if (cls.status != CLS_DONE) begin
          step_w         = 3'd1;
          emit           = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD;
        end else if (cls.cp == BOM_CP) begin
          // A byte order mark at the very start is dropped silently; elsewhere it is reported as an error.
          step_w         = cls.width;
          emit           = (adv_line != '0) || (adv_col != '0);
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BOM;
        end else begin
          step_w         = cls.width;
          emit           = 1'b1;
          res.code_point = cls.cp;
        end
      end
      ST_FAIL: begin
        upd_pos        = 1'b1;
        emit           = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_IO;
      end
      ST_END: begin
        upd_pos  = 1'b1;
        emit     = 1'b1;
        res.kind = KIND_END;
        res.last = 1'b1;
      end
      default: ;
    endcase

    // Bytes left after this step, and whether they give a result now.
    for (int j = 0; j < 4; j++) begin
      src    = 3'(j) + step_w;
      rem[j] = src[2] ? 8'h00 : buf_q[src[1:0]];
    end
    rem_cnt  = cnt_q - step_w;
    rem_cls  = classify(rem, rem_cnt);
    rem_hold = rem[0][7] && (rem_cls.status == CLS_PARTIAL);
    if (state_q == ST_DECODE) begin
      res.last = !flush_q && ((rem_cnt == 3'd0) || rem_hold);
    end
  end

  // Sequencer, with a new item taken as soon as the current one is done.
  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    flush_d   = flush_q;
    fail_d    = fail_q;
    want_load = 1'b0;
    q_pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: want_load = 1'b1;
      ST_DECODE: begin
        if (can_step) begin
          buf_d = rem;
          cnt_d = rem_cnt;
          if (hold) begin
            want_load = 1'b1;
          end else if (rem_cnt == 3'd0) begin
            if (flush_q) begin
              state_d = fail_q ? ST_FAIL : ST_END;
            end else begin
              want_load = 1'b1;
            end
          end else if (!flush_q && rem_hold) begin
            want_load = 1'b1;
          end
        end
      end
      ST_FAIL: begin
        if (can_step) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (can_step) begin
          want_load = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (want_load) begin
      state_d = ST_IDLE;
      buf_d   = rem;
      cnt_d   = rem_cnt;
      if (q_valid_i) begin
        q_pop_o = 1'b1;
        if (q_item_i.op == OP_BYTE) begin
          buf_d[rem_cnt[1:0]] = q_item_i.data;
          cnt_d               = rem_cnt + 1'b1;
          flush_d             = 1'b0;
          state_d             = ST_DECODE;
        end else begin
          flush_d = 1'b1;
          fail_d  = (q_item_i.op == OP_FAIL);
          if (rem_cnt != 3'd0) begin
            state_d = ST_DECODE;
          end else begin
            state_d = (q_item_i.op == OP_FAIL) ? ST_FAIL : ST_END;
          end
        end
      end
    end
  end

  // Position bookkeeping for each consumed unit.
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    lw_d   = lw_q;
    nl_d   = nl_q;
    if (upd_pos && can_step) begin
      line_d = adv_line;
      col_d  = adv_col;
      lw_d   = step_w;
      nl_d   = step_nl;
    end
  end

  // Output register holds a result until the receiver takes it; the decoder stalls while it is full and not taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit && can_step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      fail_q      <= 1'b0;
      line_q      <= '0;
      col_q       <= '0;
      lw_q        <= '0;
      nl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      fail_q      <= fail_d;
      line_q      <= line_d;
      col_q       <= col_d;
      lw_q        <= lw_d;
      nl_q        <= nl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pending bytes and result payload.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (emit && can_step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/utf8_char_reader_with_position.sv]
// UTF-8 character reader with source position.
// The input channel takes one source byte per transfer, or an end marker,
// or an input failure marker. The output channel gives one result per
// transfer: a decoded code point, an error report or an end report, each
// with its 1-based line and byte column; last marks the final result that
// an input item causes. Items that only start a multi-byte sequence, or
// that only drop a leading byte order mark, give no result.
// A two-entry queue sits between the input side and the decoder. An input
// item passes through the queue and the decoder's byte buffer, and its
// result is registered in the output register. The decoder takes the next
// item in the step that finishes the current one, so clean text runs at
// one byte per cycle while the receiver takes results.
// Reset empties the queue, drops held bytes and returns the position to the
// first line and column. When the receiver stalls, the result holds in the
// output register, the decoder waits, and the queue fills before the input
// side deasserts ready.
module utf8_char_reader_with_position #(
  parameter int unsigned LINE_BITS   = u8cr_pkg::DEFAULT_LINE_BITS,
  parameter int unsigned COLUMN_BITS = u8cr_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8cr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cr_pkg::out_item_t out_item_o
);
  import u8cr_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // Front end: accept and sort input items into the queue.
  u8cr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // Back end: decode, track position and drive results.
  u8cr_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/u8cr_checker.sv]
module u8cr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u8cr_pkg::out_item_t out_item_o
);
  import u8cr_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or was dropped");

  // An end report closes its item and carries no code point or error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_END) |->
      out_item_o.last && (out_item_o.code_point == '0) &&
      (out_item_o.error_code == ERR_NONE))
    else $error("malformed end report");

  // A character is a scalar value: no surrogate, nothing past the last plane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_CHAR) |->
      (out_item_o.error_code == ERR_NONE) &&
      (out_item_o.code_point <= 21'h10FFFF) &&
      !((out_item_o.code_point >= 21'h00D800) && (out_item_o.code_point <= 21'h00DFFF)))
    else $error("character is not a scalar value");

  // An error report has a known code and no code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_ERROR) |->
      (out_item_o.code_point == '0) && (out_item_o.error_code != ERR_NONE) &&
      (out_item_o.error_code <= ERR_IO))
    else $error("malformed error report");

endmodule

bind utf8_char_reader_with_position u8cr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
